// ----- sv/csbc_pkg.sv -----
`timescale 1ns / 1ps
package csbc_pkg;

  localparam int CLIP_BITS = 48;
  localparam int COEF_BITS = 32;
  // split point of a clip value for the fov product
  localparam int FOV_SPLIT = 24;
  localparam int NUM_REGS  = 7;
  localparam int CFG_ADDR_BITS = 6;

  localparam logic [2:0] REG_CLIP_X_AB = 3'd0;
  localparam logic [2:0] REG_CLIP_X_CD = 3'd1;
  localparam logic [2:0] REG_CLIP_Y_AB = 3'd2;
  localparam logic [2:0] REG_CLIP_Y_CD = 3'd3;
  localparam logic [2:0] REG_CLIP_W_AB = 3'd4;
  localparam logic [2:0] REG_CLIP_W_CD = 3'd5;
  localparam logic [2:0] REG_FOV_SCALE = 3'd6;

  localparam logic [63:0] RST_CLIP_X_AB = 64'd65536;
  localparam logic [63:0] RST_CLIP_X_CD = 64'd0;
  localparam logic [63:0] RST_CLIP_Y_AB = 64'd281474976710656;
  localparam logic [63:0] RST_CLIP_Y_CD = 64'd0;
  localparam logic [63:0] RST_CLIP_W_AB = 64'd0;
  localparam logic [63:0] RST_CLIP_W_CD = 64'd281474976710656;
  localparam logic [31:0] RST_FOV_SCALE = 32'd65536;

  typedef struct packed {
    logic [63:0] x_ab;
    logic [63:0] x_cd;
    logic [63:0] y_ab;
    logic [63:0] y_cd;
    logic [63:0] w_ab;
    logic [63:0] w_cd;
    logic [31:0] fov;
  } cfg_t;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } lane_en_t;

endpackage

// ----- sv/csbc_if.sv -----
`timescale 1ns / 1ps
interface csbc_in_if #(parameter int COORD_BITS = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_min_z;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] box_max_z;
  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z,
                box_max_x, box_max_y, box_max_z, output ready);
endinterface

// ----- sv/csbc_out_if.sv -----
`timescale 1ns / 1ps
interface csbc_out_if ();
  logic       valid;
  logic       ready;
  logic       visible;
  logic [3:0] front_corners;
  modport source (output valid, visible, front_corners, input ready);
  modport sink (input valid, visible, front_corners, output ready);
endinterface

// ----- sv/csbc_regs.sv -----
`timescale 1ns / 1ps
module csbc_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [csbc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [63:0]                        cfg_pwdata,
  output logic [63:0]                        cfg_prdata,
  output logic                               cfg_pready,
  output csbc_pkg::cfg_t                     cfg_o
);

  csbc_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  assign idx        = cfg_paddr[5:3];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_ab <= csbc_pkg::RST_CLIP_X_AB;
      cfg_r.x_cd <= csbc_pkg::RST_CLIP_X_CD;
      cfg_r.y_ab <= csbc_pkg::RST_CLIP_Y_AB;
      cfg_r.y_cd <= csbc_pkg::RST_CLIP_Y_CD;
      cfg_r.w_ab <= csbc_pkg::RST_CLIP_W_AB;
      cfg_r.w_cd <= csbc_pkg::RST_CLIP_W_CD;
      cfg_r.fov  <= csbc_pkg::RST_FOV_SCALE;
    end else if (wr) begin
      case (idx)
        csbc_pkg::REG_CLIP_X_AB: cfg_r.x_ab <= cfg_pwdata;
        csbc_pkg::REG_CLIP_X_CD: cfg_r.x_cd <= cfg_pwdata;
        csbc_pkg::REG_CLIP_Y_AB: cfg_r.y_ab <= cfg_pwdata;
        csbc_pkg::REG_CLIP_Y_CD: cfg_r.y_cd <= cfg_pwdata;
        csbc_pkg::REG_CLIP_W_AB: cfg_r.w_ab <= cfg_pwdata;
        csbc_pkg::REG_CLIP_W_CD: cfg_r.w_cd <= cfg_pwdata;
        csbc_pkg::REG_FOV_SCALE: cfg_r.fov  <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      csbc_pkg::REG_CLIP_X_AB: cfg_prdata = cfg_r.x_ab;
      csbc_pkg::REG_CLIP_X_CD: cfg_prdata = cfg_r.x_cd;
      csbc_pkg::REG_CLIP_Y_AB: cfg_prdata = cfg_r.y_ab;
      csbc_pkg::REG_CLIP_Y_CD: cfg_prdata = cfg_r.y_cd;
      csbc_pkg::REG_CLIP_W_AB: cfg_prdata = cfg_r.w_ab;
      csbc_pkg::REG_CLIP_W_CD: cfg_prdata = cfg_r.w_cd;
      csbc_pkg::REG_FOV_SCALE: cfg_prdata = {32'd0, cfg_r.fov};
      default:                 cfg_prdata = 64'd0;
    endcase
  end

endmodule

// ----- sv/csbc_lane.sv -----
`timescale 1ns / 1ps
module csbc_lane #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                        clk,
  input  csbc_pkg::lane_en_t                          en,
  input  logic signed [COORD_BITS+csbc_pkg::COEF_BITS-1:0] prod [9],
  input  logic signed [31:0]                          d_x,
  input  logic signed [31:0]                          d_y,
  input  logic signed [31:0]                          d_w,
  input  logic signed [31:0]                          fov,
  output logic signed [csbc_pkg::CLIP_BITS-1:0]       cx_o,
  output logic signed [csbc_pkg::CLIP_BITS-1:0]       cy_o,
  output logic signed [csbc_pkg::CLIP_BITS-1:0]       cw_o
);

  localparam int PW = COORD_BITS + csbc_pkg::COEF_BITS;
  localparam int SW = PW + 2;
  localparam int CB = csbc_pkg::CLIP_BITS;
  localparam int SP = csbc_pkg::FOV_SPLIT;
  localparam int HW = CB - SP + 32;
  localparam int LW = SP + 1 + 32;
  localparam int FW = CB + 33;
  localparam logic signed [SW:0] RMAX = {{(SW + 2 - CB){1'b0}}, {(CB - 1){1'b1}}};
  localparam logic signed [SW:0] RMIN = ~RMAX;
  localparam logic signed [FW-1:0] FMAX = {{(FW - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
  localparam logic signed [FW-1:0] FMIN = ~FMAX;

  // stage 2: row sums, floor, offset, saturate
  logic signed [CB-1:0] row_nxt [3];
  logic signed [CB-1:0] row_r   [3];
  logic signed [31:0]   dsel    [3];

  assign dsel[0] = d_x;
  assign dsel[1] = d_y;
  assign dsel[2] = d_w;

  always_comb begin
    logic signed [SW-1:0] sum;
    logic signed [SW:0]   t;
    for (int r = 0; r < 3; r++) begin
      sum = SW'(prod[r*3]) + SW'(prod[r*3+1]) + SW'(prod[r*3+2]);
      t   = (SW+1)'(sum >>> FRAC_BITS) + (SW+1)'(dsel[r]);
      if (t > RMAX)      row_nxt[r] = RMAX[CB-1:0];
      else if (t < RMIN) row_nxt[r] = RMIN[CB-1:0];
      else               row_nxt[r] = t[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      for (int r = 0; r < 3; r++) row_r[r] <= row_nxt[r];
    end
  end

  // stage 3: fov partial products, high and low halves
  logic signed [HW-1:0] hi_r [2];
  logic signed [LW-1:0] lo_r [2];
  logic signed [CB-1:0] w3_r;

  always_ff @(posedge clk) begin
    if (en.en3) begin
      for (int r = 0; r < 2; r++) begin
        hi_r[r] <= HW'($signed(row_r[r][CB-1:SP]) * fov);
        lo_r[r] <= LW'($signed({1'b0, row_r[r][SP-1:0]}) * fov);
      end
      w3_r <= row_r[2];
    end
  end

  // stage 4: combine, floor, saturate
  logic signed [CB-1:0] sc_nxt [2];
  logic signed [CB-1:0] sc_r   [2];
  logic signed [CB-1:0] w4_r;

  always_comb begin
    logic signed [FW-1:0] full;
    logic signed [FW-1:0] sh;
    for (int r = 0; r < 2; r++) begin
      full = (FW'(hi_r[r]) <<< SP) + FW'(lo_r[r]);
      sh   = full >>> FRAC_BITS;
      if (sh > FMAX)      sc_nxt[r] = FMAX[CB-1:0];
      else if (sh < FMIN) sc_nxt[r] = FMIN[CB-1:0];
      else                sc_nxt[r] = sh[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en4) begin
      sc_r[0] <= sc_nxt[0];
      sc_r[1] <= sc_nxt[1];
      w4_r    <= w3_r;
    end
  end

  assign cx_o = sc_r[0];
  assign cy_o = sc_r[1];
  assign cw_o = w4_r;

endmodule

// ----- sv/clip_space_box_cull.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake     | payload
// in_ch   | sink      | valid / ready | box_min_x/y/z, box_max_x/y/z
// out_ch  | source    | valid / ready | visible, front_corners
// cfg_*   | APB slave | psel/penable  | 64-bit registers at 8*index
//
// One box per cycle sustained while out_ch.ready stays high; each stage below is registered.
// Stages: corner products, row sums, fov products, fov combine, plane tests.
// Each stage holds while the next is full and stalled; bubbles are filled.
// rst_n is synchronous; it clears the valid bits and loads the registers with their reset values.
module clip_space_box_cull #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  csbc_in_if.sink                            in_ch,
  csbc_out_if.source                         out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [csbc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [63:0]                        cfg_pwdata,
  output logic [63:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int PW = COORD_BITS + csbc_pkg::COEF_BITS;
  localparam int CB = csbc_pkg::CLIP_BITS;

  csbc_pkg::cfg_t cfg;

  csbc_regs u_regs (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready), .cfg_o(cfg)
  );

  // stage valids and advance chain
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_valid_r || out_ch.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  // stage 1: each coefficient times the min and max of its axis
  logic signed [31:0]         coef [3][3];
  logic signed [COORD_BITS-1:0] crd [6];
  logic signed [PW-1:0]       prod1_r [3][6];

  assign coef[0][0] = cfg.x_ab[31:0];
  assign coef[0][1] = cfg.x_ab[63:32];
  assign coef[0][2] = cfg.x_cd[31:0];
  assign coef[1][0] = cfg.y_ab[31:0];
  assign coef[1][1] = cfg.y_ab[63:32];
  assign coef[1][2] = cfg.y_cd[31:0];
  assign coef[2][0] = cfg.w_ab[31:0];
  assign coef[2][1] = cfg.w_ab[63:32];
  assign coef[2][2] = cfg.w_cd[31:0];

  assign crd[0] = in_ch.box_min_x;
  assign crd[1] = in_ch.box_max_x;
  assign crd[2] = in_ch.box_min_y;
  assign crd[3] = in_ch.box_max_y;
  assign crd[4] = in_ch.box_min_z;
  assign crd[5] = in_ch.box_max_z;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 6; j++) begin
          prod1_r[r][j] <= PW'(coef[r][j/2] * crd[j]);
        end
      end
    end
  end

  csbc_pkg::lane_en_t lane_en;
  assign lane_en.en2 = en2;
  assign lane_en.en3 = en3;
  assign lane_en.en4 = en4;

  logic signed [CB-1:0] cx [8];
  logic signed [CB-1:0] cy [8];
  logic signed [CB-1:0] cw [8];

  for (genvar k = 0; k < 8; k++) begin : g_lane
    logic signed [PW-1:0] lp [9];
    for (genvar r = 0; r < 3; r++) begin : g_row
      assign lp[r*3]   = prod1_r[r][k % 2];
      assign lp[r*3+1] = prod1_r[r][2 + (k / 2) % 2];
      assign lp[r*3+2] = prod1_r[r][4 + k / 4];
    end
    csbc_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .en(lane_en), .prod(lp),
      .d_x(cfg.x_cd[63:32]), .d_y(cfg.y_cd[63:32]), .d_w(cfg.w_cd[63:32]),
      .fov(cfg.fov), .cx_o(cx[k]), .cy_o(cy[k]), .cw_o(cw[k])
    );
  end

  // stage 5: plane tests over the eight corners
  localparam logic signed [CB:0] ONE = (CB+1)'(1) <<< FRAC_BITS;

  logic       vis_nxt, vis_r;
  logic [3:0] cnt_nxt, cnt_r;

  always_comb begin
    logic signed [CB:0] x, y, w;
    logic fr, xl, xr, yb, yt, any_in;
    logic fl, frr, fb, ft;
    logic [2:0] nflags;
    cnt_nxt = 4'd0;
    any_in  = 1'b0;
    fl = 1'b0; frr = 1'b0; fb = 1'b0; ft = 1'b0;
    for (int k = 0; k < 8; k++) begin
      x  = (CB+1)'(cx[k]);
      y  = (CB+1)'(cy[k]);
      w  = (CB+1)'(cw[k]);
      fr = w >= ONE;
      xl = x < -w;
      xr = x > w;
      yb = y < -w;
      yt = y > w;
      cnt_nxt = cnt_nxt + {3'd0, fr};
      any_in  = any_in | (fr & !xl & !xr & !yb & !yt);
      fl  = fl  | (fr & xl);
      frr = frr | (fr & xr);
      fb  = fb  | (fr & yb);
      ft  = ft  | (fr & yt);
    end
    nflags  = {2'd0, fl} + {2'd0, frr} + {2'd0, fb} + {2'd0, ft};
    vis_nxt = any_in || ((cnt_nxt != 4'd0) && (nflags > 3'd1));
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      vis_r <= vis_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.visible       = vis_r;
  assign out_ch.front_corners = cnt_r;

endmodule

// ----- sv/csbc_checker.sv -----
`timescale 1ns / 1ps
module csbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_visible,
  input logic [3:0] out_front_corners,
  input logic       cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_visible) && $stable(out_front_corners))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_front_corners <= 4'd8)
    else $error("front corner count above eight");

  a_vis_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_front_corners != 4'd0)
    else $error("visible box with no front corner");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind clip_space_box_cull csbc_checker u_csbc_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_visible(out_ch.visible), .out_front_corners(out_ch.front_corners),
  .cfg_pready(cfg_pready)
);

// ----- tb/sv/tb_clip_space_box_cull.sv -----
`timescale 1ns / 1ps
module tb_clip_space_box_cull;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic signed [95:0] CLIP_MAX = (96'sd1 <<< (csbc_pkg::CLIP_BITS - 1)) - 96'sd1;
  localparam logic signed [95:0] CLIP_MIN = -(96'sd1 <<< (csbc_pkg::CLIP_BITS - 1));
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic [31:0] c[6];
    logic        typed;
    logic        vis;
    logic [3:0]  fc;
  } box_row_t;

  typedef struct {
    logic       vis;
    logic [3:0] fc;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [csbc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  csbc_in_if #(.COORD_BITS(32)) in_if ();
  csbc_out_if out_if ();

  clip_space_box_cull dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic [63:0] frustum_regs[csbc_pkg::NUM_REGS];
  verdict_t pending_verdicts[$];
  int boxes_sent;
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit held = 1'b0;
  bit calm;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // exact sum of one matrix row, floored and saturated
  function automatic logic signed [95:0] clip_row(input logic [63:0] ab, input logic [63:0] cd,
                                                 input logic signed [95:0] px,
                                                 input logic signed [95:0] py,
                                                 input logic signed [95:0] pz);
    logic signed [95:0] a, b, e, d, s;
    a = $signed(ab[31:0]);
    b = $signed(ab[63:32]);
    e = $signed(cd[31:0]);
    d = $signed(cd[63:32]);
    s = ((a * px + b * py + e * pz) >>> FRAC) + d;
    if (s > CLIP_MAX) s = CLIP_MAX;
    if (s < CLIP_MIN) s = CLIP_MIN;
    return s;
  endfunction

  function automatic logic signed [95:0] fov_scaled(input logic signed [95:0] v);
    logic signed [95:0] f, s;
    f = $signed(frustum_regs[csbc_pkg::REG_FOV_SCALE][31:0]);
    s = (v * f) >>> FRAC;
    if (s > CLIP_MAX) s = CLIP_MAX;
    if (s < CLIP_MIN) s = CLIP_MIN;
    return s;
  endfunction

  function automatic verdict_t cull_box(input logic [31:0] c[6]);
    logic signed [95:0] px, py, pz, cx, cy, cw;
    logic left, right, bottom, top, seen;
    int front, flags;
    verdict_t v;
    left = 0; right = 0; bottom = 0; top = 0; seen = 0; front = 0;
    for (int k = 0; k < 8; k++) begin
      px = $signed(k[0] ? c[3] : c[0]);
      py = $signed(k[1] ? c[4] : c[1]);
      pz = $signed(k[2] ? c[5] : c[2]);
      cx = fov_scaled(clip_row(frustum_regs[csbc_pkg::REG_CLIP_X_AB],
                               frustum_regs[csbc_pkg::REG_CLIP_X_CD], px, py, pz));
      cy = fov_scaled(clip_row(frustum_regs[csbc_pkg::REG_CLIP_Y_AB],
                               frustum_regs[csbc_pkg::REG_CLIP_Y_CD], px, py, pz));
      cw = clip_row(frustum_regs[csbc_pkg::REG_CLIP_W_AB],
                    frustum_regs[csbc_pkg::REG_CLIP_W_CD], px, py, pz);
      if (cw >= (96'sd1 <<< FRAC)) begin
        front++;
        if (cx >= -cw && cx <= cw && cy >= -cw && cy <= cw) seen = 1;
        left   |= cx < -cw;
        right  |= cx > cw;
        bottom |= cy < -cw;
        top    |= cy > cw;
      end
    end
    flags = left + right + bottom + top;
    v.vis = seen || (front != 0 && flags > 1);
    v.fc  = front[3:0];
    return v;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= csbc_pkg::CFG_ADDR_BITS'(idx) << 3;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx < csbc_pkg::NUM_REGS)
      frustum_regs[idx] = (idx == csbc_pkg::REG_FOV_SCALE) ? {32'd0, val[31:0]} : val;
  endtask

  task automatic send_box(input box_row_t r);
    int g, gap;
    verdict_t v;
    in_if.valid     <= 1'b1;
    in_if.box_min_x <= r.c[0];
    in_if.box_min_y <= r.c[1];
    in_if.box_min_z <= r.c[2];
    in_if.box_max_x <= r.c[3];
    in_if.box_max_y <= r.c[4];
    in_if.box_max_z <= r.c[5];
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    if (r.typed) begin
      v.vis = r.vis;
      v.fc  = r.fc;
    end else begin
      v = cull_box(r.c);
    end
    pending_verdicts.push_back(v);
    boxes_sent++;
    @(posedge clk);
    if (boxes_sent % 100 == 0) calm = ($urandom_range(0, 3) == 0);
    g = $urandom_range(0, 99);
    gap = (calm || g < 60) ? 0 : (g < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off once for a long stretch, else stall at random
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && boxes_sent >= 300) begin
      held <= 1'b1;
      hold_left <= 200;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = $urandom_range(0, 99);
      if (calm || g < 65) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        stall_left <= (g < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(negedge clk) begin
    verdict_t v;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: visible=%0b front_corners=%0d",
                   out_if.visible, out_if.front_corners);
      end else begin
        v = pending_verdicts.pop_front();
        if (out_if.visible !== v.vis || out_if.front_corners !== v.fc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: visible exp %0b got %0b, front_corners exp %0d got %0d",
                     v.vis, out_if.visible, v.fc, out_if.front_corners);
        end
      end
    end
  end

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      default: return 32'($urandom_range(0, 262144)) - 32'd131072;
    endcase
  endfunction

  function automatic box_row_t pick_box();
    box_row_t r;
    logic [31:0] p, q;
    r.typed = 0; r.vis = 0; r.fc = 0;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        p = $urandom();
        q = $urandom();
      end else begin
        p = 32'($urandom_range(0, 1048576)) - 32'd524288;
        q = p + 32'($urandom_range(0, 262144));
        if ($urandom_range(0, 9) == 0) {p, q} = {q, p};
      end
      r.c[k] = p;
      r.c[k + 3] = q;
    end
    return r;
  endfunction

  task automatic drain();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  box_row_t directed[$];

  initial begin
    logic [63:0] junk;
    rst_n = 1'b0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    in_if.valid = 0;
    in_if.box_min_x = 0; in_if.box_min_y = 0; in_if.box_min_z = 0;
    in_if.box_max_x = 0; in_if.box_max_y = 0; in_if.box_max_z = 0;
    boxes_sent = 0;
    calm = 0;
    frustum_regs[csbc_pkg::REG_CLIP_X_AB] = csbc_pkg::RST_CLIP_X_AB;
    frustum_regs[csbc_pkg::REG_CLIP_X_CD] = csbc_pkg::RST_CLIP_X_CD;
    frustum_regs[csbc_pkg::REG_CLIP_Y_AB] = csbc_pkg::RST_CLIP_Y_AB;
    frustum_regs[csbc_pkg::REG_CLIP_Y_CD] = csbc_pkg::RST_CLIP_Y_CD;
    frustum_regs[csbc_pkg::REG_CLIP_W_AB] = csbc_pkg::RST_CLIP_W_AB;
    frustum_regs[csbc_pkg::REG_CLIP_W_CD] = csbc_pkg::RST_CLIP_W_CD;
    frustum_regs[csbc_pkg::REG_FOV_SCALE] = {32'd0, csbc_pkg::RST_FOV_SCALE};

    // reset frustum: x=px, y=py, w=1.0 for every corner
    directed = '{
      '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1, 1, 4'd8},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1, 1, 4'd8},
      '{'{32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0}, 1, 0, 4'd8},
      '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1, 1, 4'd8},
      '{'{32'h0005_0000, 32'd0, 32'd0, 32'hFFFB_0000, 32'd0, 32'd0}, 1, 1, 4'd8},
      '{'{32'h0001_0000, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'd0},
        1, 1, 4'd8},
      '{'{32'h0001_0001, 32'd0, 32'd0, 32'h0001_0001, 32'd0, 32'd0}, 1, 0, 4'd8},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1}, 0, 0, 4'd0},
      '{'{32'h0002_0000, 32'h0002_0000, 32'd0, 32'h0003_0000, 32'h0003_0000, 32'd0},
        1, 1, 4'd8}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_box(directed[i]);
    repeat (150) send_box(pick_box());
    in_if.valid <= 1'b0;

    for (int ph = 1; ph <= 8; ph++) begin
      drain();
      if (ph == 8) begin
        // saturating extremes in every row
        write_reg(csbc_pkg::REG_CLIP_X_AB, 64'h7FFF_FFFF_8000_0000);
        write_reg(csbc_pkg::REG_CLIP_X_CD, 64'h8000_0000_7FFF_FFFF);
        write_reg(csbc_pkg::REG_CLIP_Y_AB, 64'h8000_0000_7FFF_FFFF);
        write_reg(csbc_pkg::REG_CLIP_Y_CD, 64'h7FFF_FFFF_8000_0000);
        write_reg(csbc_pkg::REG_CLIP_W_AB, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(csbc_pkg::REG_CLIP_W_CD, 64'h8000_0000_8000_0000);
        write_reg(csbc_pkg::REG_FOV_SCALE, 64'hFFFF_FFFF_8000_0000);
      end else begin
        write_reg(csbc_pkg::REG_CLIP_X_AB, {pick_coef(), pick_coef()});
        write_reg(csbc_pkg::REG_CLIP_X_CD, {pick_coef(), pick_coef()});
        write_reg(csbc_pkg::REG_CLIP_Y_AB, {pick_coef(), pick_coef()});
        write_reg(csbc_pkg::REG_CLIP_Y_CD, {pick_coef(), pick_coef()});
        write_reg(csbc_pkg::REG_CLIP_W_AB, {pick_coef(), pick_coef()});
        // keep w near 1.0 so corners land on both sides of the front test
        write_reg(csbc_pkg::REG_CLIP_W_CD,
                  {32'($urandom_range(0, 262144)) - 32'd65536, pick_coef()});
        junk = {$urandom(), $urandom()};
        case (ph)
          1: junk[31:0] = 32'h7FFF_FFFF;
          2: junk[31:0] = 32'h8000_0000;
          3: junk[31:0] = 32'd0;
          default: junk[31:0] = pick_coef();
        endcase
        write_reg(csbc_pkg::REG_FOV_SCALE, junk);
      end
      write_reg(REG_UNMAPPED, {$urandom(), $urandom()});
      @(posedge clk);
      repeat (145) send_box(pick_box());
      in_if.valid <= 1'b0;
    end

    drain();
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
